/* hdl/emasc_pkg.sv */
// Package: character codes, tail limits, character classes and scan state type.
`timescale 1ns / 1ps
`default_nettype none
package emasc_pkg;

    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    localparam int         TAIL_W   = 3;
    localparam logic [TAIL_W-1:0] TAIL_MIN = TAIL_W'(2);
    localparam logic [TAIL_W-1:0] TAIL_MAX = TAIL_W'(4);
    localparam logic [TAIL_W-1:0] TAIL_SAT = '1;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       is_last;
    } t_item;

    typedef struct packed {
        logic              after_at;
        logic              failed;
        logic              local_nonempty;
        logic              domain_started;
        logic              domain_dot_seen;
        logic              dot_right_after_at;
        logic              middle_ok;
        logic              tail_email_ok;
        logic              tail_alpha_ok;
        logic [TAIL_W-1:0] tail_length;
    } t_scan_state;

    localparam t_scan_state SCAN_CLEAR = '{
        after_at:           1'b0,
        failed:             1'b0,
        local_nonempty:     1'b0,
        domain_started:     1'b0,
        domain_dot_seen:    1'b0,
        dot_right_after_at: 1'b0,
        middle_ok:          1'b1,
        tail_email_ok:      1'b1,
        tail_alpha_ok:      1'b1,
        tail_length:        '0
    };

    function automatic logic is_letter(input logic [7:0] ch);
        return ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
    endfunction

    function automatic logic is_addr_char(input logic [7:0] ch);
        return is_letter(ch) || ((ch >= 8'h30) && (ch <= 8'h39)) ||
               (ch == CH_UNDER) || (ch == CH_DOT) || (ch == CH_DASH);
    endfunction

endpackage
`default_nettype wire

/* hdl/emasc_in_stage.sv */
// Input register: holds one accepted transaction until the scanner consumes it.
`timescale 1ns / 1ps
`default_nettype none
module emasc_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  emasc_pkg::t_item    i_item,
    output logic                o_ready,
    output logic                o_valid,
    output emasc_pkg::t_item    o_item,
    input  wire                 i_take
);
    import emasc_pkg::*;

    logic  r_vld;
    t_item r_item;

    assign o_ready = !r_vld || i_take;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/emasc_scan.sv */
// Scanner: per-byte state update and verdict on the final byte of a string.
`timescale 1ns / 1ps
`default_nettype none
module emasc_scan (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  emasc_pkg::t_item    i_item,
    output logic                o_verdict
);
    import emasc_pkg::*;

    t_scan_state r_st;
    t_scan_state n_st;
    logic [7:0]  ch;

    assign ch = i_item.byte_value;

    always_comb begin
        n_st = r_st;
        if (ch == CH_AT) begin
            if (r_st.after_at || !r_st.local_nonempty) begin
                n_st.failed = 1'b1;
            end
            n_st.after_at      = 1'b1;
            n_st.tail_email_ok = 1'b1;
            n_st.tail_alpha_ok = 1'b1;
            n_st.tail_length   = '0;
        end else if (!r_st.after_at) begin
            n_st.local_nonempty = 1'b1;
            if (!is_addr_char(ch)) begin
                n_st.failed = 1'b1;
            end
        end else if (ch == CH_DOT) begin
            n_st.middle_ok          = r_st.middle_ok && r_st.tail_email_ok;
            n_st.dot_right_after_at = !r_st.domain_started;
            n_st.domain_dot_seen    = 1'b1;
            n_st.domain_started     = 1'b1;
            n_st.tail_email_ok      = 1'b1;
            n_st.tail_alpha_ok      = 1'b1;
            n_st.tail_length        = '0;
        end else begin
            n_st.domain_started = 1'b1;
            if (!is_addr_char(ch)) begin
                n_st.tail_email_ok = 1'b0;
            end
            if (!is_letter(ch)) begin
                n_st.tail_alpha_ok = 1'b0;
            end
            if (r_st.tail_length != TAIL_SAT) begin
                n_st.tail_length = r_st.tail_length + TAIL_W'(1);
            end
        end
    end

    assign o_verdict = !n_st.failed && n_st.after_at && n_st.domain_dot_seen &&
                       !n_st.dot_right_after_at && n_st.middle_ok && n_st.tail_alpha_ok &&
                       (n_st.tail_length inside {[TAIL_MIN:TAIL_MAX]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= SCAN_CLEAR;
        end else if (i_step) begin
            r_st <= i_item.is_last ? SCAN_CLEAR : n_st;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.is_last) |=> (r_st == SCAN_CLEAR))
        else $error("scan state not cleared after final byte");

    a_tail_needs_at: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.tail_length != '0) |-> r_st.after_at)
        else $error("tail counted before '@'");

    a_dot_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.dot_right_after_at || r_st.domain_started) |-> r_st.after_at)
        else $error("domain flags set without '@'");

endmodule
`default_nettype wire

/* hdl/emasc_out_stage.sv */
// Result register: holds one verdict until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none
module emasc_out_stage (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_load,
    input  wire   i_res,
    output logic  o_free,
    output logic  o_valid,
    output logic  o_res,
    input  wire   i_ready
);
    logic r_vld;
    logic r_res;

    assign o_free  = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

/* hdl/email_address_syntax_check_top.sv */
// Top level: streaming e-mail address syntax checker.
// Input channel: one byte per transaction (i_byte_value), i_is_last marks the
// final byte of a string. Output channel: one verdict (o_valid_res) per string,
// given for the final byte only; other bytes produce no output transaction.
// The final byte of a string passes through the input register; its verdict
// is then loaded into the result register, where the receiver takes it.
// Throughput: one byte per cycle through the scan update between the two
// registers, except while a final byte waits behind a full result register.
// While the receiver stalls, the result register holds its verdict; bytes that
// are not final still flow through the scanner, and the input stops only when
// a final byte waits behind a full result register.
// Reset (synchronous, active low) empties both registers and clears the scan
// state; the scan state also clears itself after every final byte.
`timescale 1ns / 1ps
`default_nettype none
module email_address_syntax_check_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_byte_value,
    input  wire         i_is_last,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_valid_res
);
    import emasc_pkg::*;

    t_item in_item;
    t_item stage_item;
    logic  stage_vld;
    logic  out_free;
    logic  step;
    logic  verdict;

    assign in_item.byte_value = i_byte_value;
    assign in_item.is_last    = i_is_last;

    assign step = stage_vld && (!stage_item.is_last || out_free);

    emasc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .o_ready (o_in_ready),
        .o_valid (stage_vld),
        .o_item  (stage_item),
        .i_take  (step)
    );

    emasc_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_item    (stage_item),
        .o_verdict (verdict)
    );

    emasc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && stage_item.is_last),
        .i_res   (verdict),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .o_res   (o_valid_res),
        .i_ready (i_out_ready)
    );

endmodule
`default_nettype wire
